// ===== hdl/ndb_pkg.sv =====
package ndb_pkg;

   // peer store geometry
   localparam int NEIGHBORS = 64;
   localparam int MAC_BITS  = 48;
   localparam int IDX_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int CNT_W     = $clog2(NEIGHBORS + 1);

   // field widths
   localparam int SEC_W  = 12;
   localparam int NS_W   = 30;
   localparam int RND_W  = 16;
   localparam int IP_W   = 64;
   localparam int OCNT_W = 7;

   // channel widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 184;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_S  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NS = 4'd1;

   // timing constants
   localparam int LIMIT_S       = 3600;
   localparam int DELAY_MAX     = 4095;
   localparam int BASE_S_RESET  = 10;
   localparam int REARM_OFFSET  = 2;

   // remainder unit: one dividend bit per step
   localparam int DIV_STEPS = RND_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      MODE_EXPIRY   = 2'd0,
      MODE_ANNOUNCE = 2'd1,
      MODE_DISABLE  = 2'd2,
      MODE_ENABLE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_FINISH
   } state_type;

   // search token passed along the row of cells
   typedef struct packed {
      logic                valid;
      logic                hit;
      logic [MAC_BITS-1:0] mac;
   } probe_type;

   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [SEC_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [SEC_W-1:0] rem;
   } div_rsp_type;

   // clamp a seconds value to the 12-bit delay field
   function automatic logic [SEC_W-1:0] sat_delay(input logic [SEC_W:0] d);
      logic [SEC_W-1:0] r;
      if (d > (SEC_W+1)'(DELAY_MAX)) begin
         r = SEC_W'(DELAY_MAX);
      end else begin
         r = d[SEC_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/neighbor_discovery_backoff.sv =====
// Neighbour discovery with exponential announce backoff.
// req channel: one event per transfer; req_tuser carries the event kind
// (timer expiry, announce received, disable, enable), req_tdata the peer
// address, its IP text and a random value for jitter.
// rsp channel: exactly one result per event, with the timer and announce
// requests, the new-neighbour notice and the neighbour count.
// csr channel: index 0 base period in seconds, index 1 nanosecond part;
// always ready. The user must write it only while no event is in flight;
// the block does not enforce this. An announce walks a token through a
// row of NEIGHBORS cells, one cell per cycle, before its result is formed.
// Other events are bound by the 16-step remainder unit for jitter. One
// event is worked on at a time; req_tready returns the cycle after the
// result is registered.
// A finished result sits in the output register; a new event is taken
// while it waits, and the next result holds back until rsp_tready.
// Reset: discovery enabled, period 10 s, empty peer store, no result held.
module neighbor_discovery_backoff (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // peer_mac[47:0], peer_ip_high[111:48], peer_ip_low[175:112],
   // random_value[191:176]
   input  logic [ndb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // send_announce[0], cancel_timer[1], arm_timer[2], delay_s[14:3],
   // delay_ns[44:15], new_neighbor[45], neighbor_ip_high[109:46],
   // neighbor_ip_low[173:110], neighbor_count[180:174], table_full[181],
   // zero[183:182]
   output logic [ndb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ndb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ndb_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ndb_pkg::*;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [IP_W-1:0]      ip_high_ff, ip_high_in;
   logic [IP_W-1:0]      ip_low_ff, ip_low_in;
   logic                 rnd_lsb_ff, rnd_lsb_in;
   logic [MAC_BITS-1:0]  mac_ff, mac_in;
   logic                 hit_ff, hit_in;
   logic                 enabled_ff, enabled_in;
   logic [SEC_W-1:0]     period_ff, period_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [SEC_W-1:0]     base_s_ff, base_s_in;
   logic [NS_W-1:0]      base_ns_ff, base_ns_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_xfer;
   probe_type            link [NEIGHBORS+1];
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic                 wr_en;

   // result fields
   logic                 send;
   logic                 cancel;
   logic                 arm;
   logic [SEC_W-1:0]     dly_s;
   logic [NS_W-1:0]      dly_ns;
   logic                 new_nb;
   logic [IP_W-1:0]      nb_ip_high;
   logic [IP_W-1:0]      nb_ip_low;
   logic                 full;

   // delay arithmetic
   logic [SEC_W-1:0]     jitter_s;
   logic [SEC_W-1:0]     rearm_s;
   logic [SEC_W:0]       doubled;
   logic [SEC_W-1:0]     grown;
   logic [SEC_W-1:0]     expiry_s;

   assign req_xfer  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // reset rearm: (random % base) + 2, jitter zero when base is zero
   assign jitter_s = (base_s_ff == '0) ? '0 : div_rsp.rem;
   assign rearm_s  = sat_delay({1'b0, jitter_s} + (SEC_W+1)'(REARM_OFFSET));

   // backoff: double while it stays under the limit, add 0 or 1 s
   assign doubled  = {period_ff, 1'b0};
   assign grown    = (doubled < (SEC_W+1)'(LIMIT_S)) ? doubled[SEC_W-1:0] : period_ff;
   assign expiry_s = sat_delay({1'b0, grown} + (SEC_W+1)'(rnd_lsb_ff));

   // search token enters the row on the announce transfer
   assign link[0] = '{valid: req_xfer && (mode_type'(req_tuser) == MODE_ANNOUNCE),
                      hit:   1'b0,
                      mac:   req_tdata[MAC_BITS-1:0]};

   assign div_req = '{start:    req_xfer,
                      dividend: req_tdata[191:176],
                      divisor:  base_s_ff};

   // row of peer cells
   for (genvar g = 0; g < NEIGHBORS; g++) begin : g_cell
      ndb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(g)),
         .total     (total_ff),
         .wr_en     (wr_en),
         .wr_idx    (total_ff[IDX_W-1:0]),
         .wr_mac    (mac_ff),
         .probe_in  (link[g]),
         .probe_out (link[g+1])
      );
   end

   ndb_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer: next state, state updates and result
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ip_high_in   = ip_high_ff;
      ip_low_in    = ip_low_ff;
      rnd_lsb_in   = rnd_lsb_ff;
      mac_in       = mac_ff;
      hit_in       = hit_ff;
      enabled_in   = enabled_ff;
      period_in    = period_ff;
      total_in     = total_ff;
      base_s_in    = base_s_ff;
      base_ns_in   = base_ns_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == ST_IDLE);
      wr_en        = 1'b0;
      send         = 1'b0;
      cancel       = 1'b0;
      arm          = 1'b0;
      dly_s        = '0;
      dly_ns       = '0;
      new_nb       = 1'b0;
      nb_ip_high   = '0;
      nb_ip_low    = '0;
      full         = 1'b0;

      // register writes
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BASE_S) begin
            base_s_in = csr_data[SEC_W-1:0];
         end else if (csr_index == CSR_BASE_NS) begin
            base_ns_in = csr_data[NS_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in    = mode_type'(req_tuser);
               mac_in     = req_tdata[MAC_BITS-1:0];
               ip_high_in = req_tdata[111:48];
               ip_low_in  = req_tdata[175:112];
               rnd_lsb_in = req_tdata[176];
               state_in   = ST_WORK;
            end
         end
         ST_WORK: begin
            if (mode_ff != MODE_ANNOUNCE) begin
               hit_in   = 1'b0;
               state_in = ST_FINISH;
            end else if (link[NEIGHBORS].valid) begin
               hit_in   = link[NEIGHBORS].hit;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!div_rsp.busy && (!rsp_valid_ff || rsp_tready)) begin
               unique case (mode_ff)
                  MODE_EXPIRY: begin
                     if (enabled_ff) begin
                        send      = 1'b1;
                        arm       = 1'b1;
                        period_in = grown;
                        dly_s     = expiry_s;
                     end
                  end
                  MODE_ANNOUNCE: begin
                     if (!hit_ff) begin
                        if (total_ff >= CNT_W'(NEIGHBORS)) begin
                           full = 1'b1;
                        end else begin
                           wr_en      = 1'b1;
                           total_in   = total_ff + 1'b1;
                           new_nb     = 1'b1;
                           nb_ip_high = ip_high_ff;
                           nb_ip_low  = ip_low_ff;
                           if (enabled_ff) begin
                              cancel    = 1'b1;
                              arm       = 1'b1;
                              period_in = base_s_ff;
                              dly_s     = rearm_s;
                           end
                        end
                     end
                  end
                  MODE_DISABLE: begin
                     if (enabled_ff) begin
                        enabled_in = 1'b0;
                        cancel     = 1'b1;
                     end
                  end
                  MODE_ENABLE: begin
                     if (!enabled_ff) begin
                        enabled_in = 1'b1;
                        arm        = 1'b1;
                        period_in  = base_s_ff;
                        dly_s      = rearm_s;
                     end
                  end
                  default: begin
                  end
               endcase
               if (arm) begin
                  dly_ns = base_ns_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, full, OCNT_W'(total_in), nb_ip_low, nb_ip_high,
                               new_nb, dly_ns, dly_s, arm, cancel, send};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= 1'b1;
         period_ff    <= SEC_W'(BASE_S_RESET);
         total_ff     <= '0;
         base_s_ff    <= SEC_W'(BASE_S_RESET);
         base_ns_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         period_ff    <= period_in;
         total_ff     <= total_in;
         base_s_ff    <= base_s_in;
         base_ns_ff   <= base_ns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // event and result payload
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      mac_ff      <= mac_in;
      ip_high_ff  <= ip_high_in;
      ip_low_ff   <= ip_low_in;
      rnd_lsb_ff  <= rnd_lsb_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/ndb_cell.sv =====
module ndb_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ndb_pkg::IDX_W-1:0]     cell_idx,
   input  logic [ndb_pkg::CNT_W-1:0]     total,
   input  logic                          wr_en,
   input  logic [ndb_pkg::IDX_W-1:0]     wr_idx,
   input  logic [ndb_pkg::MAC_BITS-1:0]  wr_mac,
   input  ndb_pkg::probe_type            probe_in,
   output ndb_pkg::probe_type            probe_out
);
   import ndb_pkg::*;

   logic [MAC_BITS-1:0] entry_ff;
   logic                valid_ff;
   logic                hit_ff;
   logic [MAC_BITS-1:0] mac_ff;
   logic                match;

   // entry counts only when it lies below the fill count
   assign match = probe_in.valid && (CNT_W'(cell_idx) < total) && (entry_ff == probe_in.mac);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= probe_in.valid;
      end
   end

   // token payload moves on every cycle
   always_ff @(posedge clock) begin
      hit_ff <= probe_in.hit | match;
      mac_ff <= probe_in.mac;
   end

   // stored address, written when the fill count points here
   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == cell_idx)) begin
         entry_ff <= wr_mac;
      end
   end

   assign probe_out = '{valid: valid_ff, hit: hit_ff, mac: mac_ff};

endmodule

// ===== hdl/ndb_rem.sv =====
module ndb_rem (
   input  logic                 clock,
   input  logic                 reset,
   input  ndb_pkg::div_req_type div_req,
   output ndb_pkg::div_rsp_type div_rsp
);
   import ndb_pkg::*;

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [SEC_W-1:0]     rem_ff, rem_in;
   logic [RND_W-1:0]     quo_ff, quo_in;
   logic [SEC_W-1:0]     divisor_ff, divisor_in;
   logic [SEC_W:0]       trial;
   logic [SEC_W-1:0]     step_rem;

   // restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[RND_W-1]};
      if (trial >= {1'b0, divisor_ff}) begin
         step_rem = SEC_W'(trial - {1'b0, divisor_ff});
      end else begin
         step_rem = trial[SEC_W-1:0];
      end
   end

   always_comb begin
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         count_in   = DIV_CNT_W'(DIV_STEPS);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         rem_in   = step_rem;
         quo_in   = {quo_ff[RND_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp = '{busy: (count_ff != '0), rem: rem_ff};

endmodule

// ===== tb/ndb_scoreboard.sv =====
module ndb_scoreboard (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ndb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ndb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ndb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ndb_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             faults,
   output int                             owed,
   output int                             checked,
   output int                             notices,
   output int                             drops
);
   import ndb_pkg::*;

   typedef struct packed {
      logic              send_announce;
      logic              cancel_timer;
      logic              arm_timer;
      logic [SEC_W-1:0]  delay_s;
      logic [NS_W-1:0]   delay_ns;
      logic              new_neighbor;
      logic [IP_W-1:0]   ip_high;
      logic [IP_W-1:0]   ip_low;
      logic [OCNT_W-1:0] neighbor_count;
      logic              table_full;
      logic [1:0]        pad;
   } timer_response_type;

   // mirrored block state and register copies
   logic                enabled;
   int unsigned         period_s;
   int unsigned         base_s;
   logic [NS_W-1:0]     base_ns;
   logic [MAC_BITS-1:0] peers [NEIGHBORS];
   int unsigned         peer_total;
   timer_response_type  owed_responses [$];

   initial begin
      faults  = 0;
      owed    = 0;
      checked = 0;
      notices = 0;
      drops   = 0;
   end

   function automatic logic [SEC_W-1:0] clamp_delay(input int unsigned secs);
      return (secs > DELAY_MAX) ? SEC_W'(DELAY_MAX) : SEC_W'(secs);
   endfunction

   // backoff restart: period back to base, delay base-bounded jitter plus offset
   function automatic logic [SEC_W-1:0] restart_backoff(input logic [RND_W-1:0] rnd);
      int unsigned jitter;
      jitter   = 0;
      period_s = base_s;
      if (base_s != 0) begin
         jitter = rnd % base_s;
      end
      return clamp_delay(jitter + REARM_OFFSET);
   endfunction

   function automatic timer_response_type resolve_event(
      input mode_type            kind,
      input logic [MAC_BITS-1:0] mac,
      input logic [IP_W-1:0]     ip_high,
      input logic [IP_W-1:0]     ip_low,
      input logic [RND_W-1:0]    rnd
   );
      timer_response_type r;
      logic               known;
      r     = '0;
      known = 1'b0;
      case (kind)
         MODE_EXPIRY: begin
            if (enabled) begin
               r.send_announce = 1'b1;
               if (period_s * 2 < LIMIT_S) begin
                  period_s = period_s * 2;
               end
               r.arm_timer = 1'b1;
               r.delay_s   = clamp_delay(period_s + rnd[0]);
            end
         end
         MODE_ANNOUNCE: begin
            for (int i = 0; i < peer_total; i++) begin
               if (peers[IDX_W'(i)] == mac) begin
                  known = 1'b1;
               end
            end
            if (!known) begin
               if (peer_total >= NEIGHBORS) begin
                  r.table_full = 1'b1;
               end else begin
                  peers[IDX_W'(peer_total)] = mac;
                  peer_total++;
                  if (enabled) begin
                     r.cancel_timer = 1'b1;
                     r.arm_timer    = 1'b1;
                     r.delay_s      = restart_backoff(rnd);
                  end
                  r.new_neighbor = 1'b1;
                  r.ip_high      = ip_high;
                  r.ip_low       = ip_low;
               end
            end
         end
         MODE_DISABLE: begin
            if (enabled) begin
               enabled        = 1'b0;
               r.cancel_timer = 1'b1;
            end
         end
         MODE_ENABLE: begin
            if (!enabled) begin
               enabled     = 1'b1;
               r.arm_timer = 1'b1;
               r.delay_s   = restart_backoff(rnd);
            end
         end
      endcase
      if (r.arm_timer) begin
         r.delay_ns = base_ns;
      end
      r.neighbor_count = OCNT_W'(peer_total);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin : watch
      timer_response_type want;
      timer_response_type got;
      if (reset) begin
         enabled    = 1'b1;
         period_s   = BASE_S_RESET;
         base_s     = BASE_S_RESET;
         base_ns    = '0;
         peer_total = 0;
         owed_responses.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BASE_S) begin
               base_s = 32'(csr_data[SEC_W-1:0]);
            end else if (csr_index == CSR_BASE_NS) begin
               base_ns = csr_data[NS_W-1:0];
            end
         end
         // response transfer against the oldest owed response
         if (rsp_tvalid && rsp_tready) begin
            got.send_announce  = rsp_tdata[0];
            got.cancel_timer   = rsp_tdata[1];
            got.arm_timer      = rsp_tdata[2];
            got.delay_s        = rsp_tdata[14:3];
            got.delay_ns       = rsp_tdata[44:15];
            got.new_neighbor   = rsp_tdata[45];
            got.ip_high        = rsp_tdata[109:46];
            got.ip_low         = rsp_tdata[173:110];
            got.neighbor_count = rsp_tdata[180:174];
            got.table_full     = rsp_tdata[181];
            got.pad            = rsp_tdata[183:182];
            if (owed_responses.size() == 0) begin
               $display("%0t: response with none owed, expected nothing actual %h",
                        $time, rsp_tdata);
               faults++;
            end else begin
               want = owed_responses.pop_front();
               check_field("send_announce", want.send_announce, got.send_announce);
               check_field("cancel_timer", want.cancel_timer, got.cancel_timer);
               check_field("arm_timer", want.arm_timer, got.arm_timer);
               check_field("delay_s", want.delay_s, got.delay_s);
               check_field("delay_ns", want.delay_ns, got.delay_ns);
               check_field("new_neighbor", want.new_neighbor, got.new_neighbor);
               check_field("neighbor_ip_high", want.ip_high, got.ip_high);
               check_field("neighbor_ip_low", want.ip_low, got.ip_low);
               check_field("neighbor_count", want.neighbor_count, got.neighbor_count);
               check_field("table_full", want.table_full, got.table_full);
               check_field("padding", want.pad, got.pad);
               checked++;
            end
         end
         // event transfer: work out its response now
         if (req_tvalid && req_tready) begin
            want = resolve_event(mode_type'(req_tuser), req_tdata[MAC_BITS-1:0],
                                 req_tdata[111:48], req_tdata[175:112],
                                 req_tdata[191:176]);
            if (want.new_neighbor) notices++;
            if (want.table_full) drops++;
            owed_responses.push_back(want);
         end
      end
      owed = owed_responses.size();
   end

endmodule

// ===== tb/tb_neighbor_discovery_backoff.sv =====
module tb_neighbor_discovery_backoff;
   import ndb_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 212;
   localparam int POOL        = 72;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // peer_mac, peer_ip_high, peer_ip_low, random_value
   logic [1:0]            req_tuser;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // send_announce .. table_full, zero pad
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic calm         = 1'b0;
   logic hold_request = 1'b0;
   int   faults, owed, checked, notices, drops;
   int   sent [4];
   int   settings_used = 0;
   int   announces     = 0;

   logic [MAC_BITS-1:0] mac_pool [POOL];
   logic [SEC_W-1:0]    phase_s  [PHASES];
   logic [NS_W-1:0]     phase_ns [PHASES];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   neighbor_discovery_backoff dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ndb_scoreboard scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .faults     (faults),
      .owed       (owed),
      .checked    (checked),
      .notices    (notices),
      .drops      (drops)
   );

   // one event transfer; returns at the accepting edge
   task automatic send_event(input mode_type kind, input logic [MAC_BITS-1:0] mac,
                             input logic [IP_W-1:0] ip_high, input logic [IP_W-1:0] ip_low,
                             input logic [RND_W-1:0] rnd);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {rnd, ip_low, ip_high, mac};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent[kind]++;
   endtask

   task automatic random_event();
      logic [MAC_BITS-1:0] mac;
      mode_type            kind;
      int                  pick;
      int                  span;
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = MODE_EXPIRY;
      else if (pick < 70) kind = MODE_ANNOUNCE;
      else if (pick < 85) kind = MODE_DISABLE;
      else kind = MODE_ENABLE;
      mac = MAC_BITS'({$urandom, $urandom});
      // announces mostly come from a pool that widens over the run
      if (kind == MODE_ANNOUNCE) begin
         if ($urandom_range(0, 15) != 0) begin
            span = 8 + announces / 8;
            if (span > POOL) span = POOL;
            mac = mac_pool[$urandom_range(0, span - 1)];
         end
         announces++;
      end
      send_event(kind, mac, {$urandom, $urandom}, {$urandom, $urandom}, RND_W'($urandom));
   endtask

   task automatic sender_gap(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop offering and wait until every owed response has been taken
   task automatic await_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed != 0) @(negedge clock);
   endtask

   task automatic await_csr();
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // both period registers, written only while the block is idle
   task automatic program_periods(input logic [SEC_W-1:0] secs, input logic [NS_W-1:0] nsec);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE_S;
      csr_data  <= CSR_DATA_W'(secs);
      await_csr();
      @(negedge clock);
      csr_index <= CSR_BASE_NS;
      csr_data  <= CSR_DATA_W'(nsec);
      await_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // response side: random short stalls, one long hold on request
   initial begin : response_sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      for (int i = 0; i < 4; i++) sent[i] = 0;
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      mac_pool[2] = 48'h5555_5555_5555;
      mac_pool[3] = 48'hAAAA_AAAA_AAAA;
      for (int i = 4; i < POOL; i++) mac_pool[i] = MAC_BITS'({$urandom, $urandom});
      phase_s  = '{12'd1, 12'd3600, 12'd0, 12'd4095, 12'd1, 12'd2, 12'd1800};
      phase_ns = '{30'd0, 30'd999_999_999, 30'd0, '1, 30'd0, 30'd1, 30'd0};
      phase_s[4]  = SEC_W'($urandom_range(1, 3600));
      phase_ns[2] = NS_W'($urandom_range(0, 999_999_999));
      phase_ns[4] = NS_W'($urandom_range(0, 999_999_999));
      phase_ns[6] = NS_W'($urandom_range(0, 999_999_999));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      program_periods(SEC_W'(BASE_S_RESET), '0);

      // directed: expiry backoff, new and known peers, disable/enable paths
      send_event(MODE_EXPIRY, '0, '0, '0, 16'h0001);
      send_event(MODE_EXPIRY, '1, '1, '1, 16'hFFFF);
      send_event(MODE_ANNOUNCE, mac_pool[0], '0, '0, 16'hFFFF);
      send_event(MODE_ANNOUNCE, mac_pool[1], '1, '1, 16'h0000);
      send_event(MODE_ANNOUNCE, mac_pool[0], {$urandom, $urandom}, {$urandom, $urandom},
                 16'h1234);
      send_event(MODE_DISABLE, '0, '0, '0, 16'h0000);
      send_event(MODE_DISABLE, '0, '0, '0, 16'h0000);
      send_event(MODE_EXPIRY, '0, '0, '0, 16'h0001);
      send_event(MODE_ANNOUNCE, mac_pool[2], 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 16'h8001);
      send_event(MODE_ENABLE, '0, '0, '0, RND_W'($urandom));
      send_event(MODE_ENABLE, '0, '0, '0, RND_W'($urandom));
      // doubling until the cap holds the period
      repeat (9) send_event(MODE_EXPIRY, '0, '0, '0, RND_W'($urandom));

      // widest base: both the restart and the expiry delay saturate
      await_responses();
      program_periods('1, '1);
      send_event(MODE_ANNOUNCE, mac_pool[3], '1, '0, 16'd4094);
      send_event(MODE_EXPIRY, '0, '0, '0, 16'h0001);

      // zero base: restart jitter drops out
      await_responses();
      program_periods('0, '0);
      send_event(MODE_ANNOUNCE, MAC_BITS'({$urandom, $urandom}), '0, '1, 16'hFFFF);
      send_event(MODE_DISABLE, '0, '0, '0, 16'h0000);
      send_event(MODE_ENABLE, '0, '0, '0, 16'hFFFF);

      // random phases, one period setting each; the last without idling
      for (int p = 0; p < PHASES; p++) begin
         await_responses();
         program_periods(phase_s[p], phase_ns[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            random_event();
            if (k == 0) calm = (p == PHASES - 1);
            if (p == 1 && k == 40) hold_request = 1'b1;
            if (p == 2 && k == 100) await_responses();
            if (!calm && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 4));
         end
      end

      await_responses();
      repeat (2 * NEIGHBORS) @(negedge clock);

      $display("Events: %0d expiries, %0d announces, %0d disables, %0d enables, %0d settings.",
               sent[MODE_EXPIRY], sent[MODE_ANNOUNCE], sent[MODE_DISABLE],
               sent[MODE_ENABLE], settings_used);
      $display("Responses compared: %0d; peers stored %0d, dropped on full store %0d.",
               checked, notices, drops);
      if (faults == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // run limit, several times the slowest legal run
   initial begin : watchdog
      #6_000_000;
      $display("Timed out with %0d responses still owed.", owed);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ndb_pkg.sv
hdl/ndb_cell.sv
hdl/ndb_rem.sv
hdl/neighbor_discovery_backoff.sv
tb/ndb_scoreboard.sv
tb/tb_neighbor_discovery_backoff.sv
